[hw/rtl/rswd_pkg.sv]
// Shared types, constants and the sensor unit-vector function for the
// ring sensor window direction block. No dependencies.
package rswd_pkg;

	localparam int SENSOR_COUNT_DEF = 32;
	localparam int ANGLE_BITS_DEF   = 16;

	localparam int BITS_W   = 32;  // width of the sensor snapshot
	localparam int IDX_W    = 5;   // center and half-width fields
	localparam int POS_W    = 6;   // ring index, covers up to 64 sensors
	localparam int SPAN_W   = 6;   // 2 * half width, up to 62
	localparam int HIT_W    = 6;   // up to 63 covered positions
	localparam int DIR_W    = 16;
	localparam int TRIG_W   = 16;  // Q1.14 cosine / sine
	localparam int SUM_W    = 22;  // 63 * 16384 fits with sign
	localparam int XY_W     = 40;  // sums scaled by 2^16 plus CORDIC growth
	localparam int PHASE_W  = 32;
	localparam int CORDIC_STEPS = 30;
	localparam longint CORDIC_X0 = 652032874;

	localparam longint ATAN_TURN [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	typedef struct packed {
		logic [BITS_W-1:0] sensor_bits;
		logic [IDX_W-1:0]  window_center;
		logic [IDX_W-1:0]  window_half_width;
	} rswd_in_t;

	typedef struct packed {
		logic             found;
		logic [DIR_W-1:0] direction;
		logic [HIT_W-1:0] hit_count;
	} rswd_out_t;

	// Travels along the sensor cells.
	typedef struct packed {
		logic [BITS_W-1:0]       sensor_bits;
		logic [POS_W-1:0]        start_pos;
		logic [SPAN_W-1:0]       span;
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic [HIT_W-1:0]        hits;
	} rswd_scan_t;

	// Travels along the vectoring cells.
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [PHASE_W-1:0]     ang;
		logic                   zero;
		logic [HIT_W-1:0]       hits;
	} rswd_rot_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} rswd_trig_t;

	// Cosine and sine of a 32-bit phase in Q1.14, by a fixed rotation pass.
	// Evaluated at elaboration only, to build each cell's constants.
	function automatic rswd_trig_t trig_of_phase(input logic [PHASE_W-1:0] phase);
		logic [PHASE_W-1:0] p;
		logic               flip;
		longint             x;
		longint             y;
		longint             z;
		longint             dx;
		longint             dy;
		rswd_trig_t         t;
		flip = (phase >= 32'h4000_0000) && (phase < 32'hC000_0000);
		p = flip ? (phase - 32'h8000_0000) : phase;
		z = longint'($signed(p));
		x = CORDIC_X0;
		y = 0;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TURN[k];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TURN[k];
			end
		end
		x = (x + 32768) >>> 16;
		y = (y + 32768) >>> 16;
		if (flip) begin
			x = -x;
			y = -y;
		end
		t.cos_v = TRIG_W'(x);
		t.sin_v = TRIG_W'(y);
		return t;
	endfunction

endpackage

[hw/rtl/rswd_sensor_cell.sv]
// One sensor position of the scan chain: adds its weighted unit vector
// when the window covers it and the sensor sees line. Depends on rswd_pkg.
module rswd_sensor_cell #(
	parameter int SENSOR_COUNT = rswd_pkg::SENSOR_COUNT_DEF,
	parameter int INDEX        = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  rswd_pkg::rswd_scan_t scan_in,
	output logic                vld_out,
	output rswd_pkg::rswd_scan_t scan_out
);
	import rswd_pkg::*;

	localparam int MAX_COVER = 62 / SENSOR_COUNT + 1;
	localparam int CNT_W     = $clog2(MAX_COVER + 1);
	localparam logic [PHASE_W-1:0] PHASE =
		PHASE_W'((64'(INDEX) << 32) / SENSOR_COUNT);
	localparam rswd_trig_t TRIG = trig_of_phase(PHASE);
	localparam logic [POS_W:0] IDX_E = (POS_W + 1)'(INDEX);
	localparam logic [POS_W:0] NUM_E = (POS_W + 1)'(SENSOR_COUNT);

	logic [POS_W:0]          start_e;
	logic [POS_W:0]          offset;
	logic [CNT_W-1:0]        cover_cnt;
	logic                    line;
	logic [CNT_W-1:0]        weight;
	logic signed [SUM_W-1:0] weight_s;
	logic signed [SUM_W-1:0] cos_s;
	logic signed [SUM_W-1:0] sin_s;
	logic signed [SUM_W-1:0] sx_in;
	logic signed [SUM_W-1:0] sy_in;
	rswd_scan_t              scan_nxt;
	logic                    vld_q;
	rswd_scan_t              scan_q;

	// Sensors past the snapshot width never see line.
	generate
		if (INDEX < BITS_W) begin : g_bit
			assign line = ~scan_in.sensor_bits[INDEX];
		end else begin : g_none
			assign line = 1'b0;
		end
	endgenerate

	// Distance from the window start, then how many times the window wraps over it.
	always_comb begin
		start_e = {1'b0, scan_in.start_pos};
		offset = (IDX_E >= start_e) ? (IDX_E - start_e) : (IDX_E + NUM_E - start_e);
		cover_cnt = '0;
		for (int k = 0; k < MAX_COVER; k++) begin
			if ((11'(offset) + 11'(k * SENSOR_COUNT)) <= 11'(scan_in.span))
				cover_cnt = cover_cnt + CNT_W'(1);
		end
	end

	always_comb begin
		weight   = line ? cover_cnt : '0;
		weight_s = SUM_W'(weight);
		cos_s    = SUM_W'(TRIG.cos_v);
		sin_s    = SUM_W'(TRIG.sin_v);
		sx_in    = scan_in.sum_x;
		sy_in    = scan_in.sum_y;
		scan_nxt       = scan_in;
		scan_nxt.sum_x = sx_in + weight_s * cos_s;
		scan_nxt.sum_y = sy_in + weight_s * sin_s;
		scan_nxt.hits  = scan_in.hits + HIT_W'(weight);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_nxt;
	end

	assign vld_out  = vld_q;
	assign scan_out = scan_q;

endmodule

[hw/rtl/rswd_cordic_cell.sv]
// One vectoring iteration of the atan2 chain, registered.
// Depends on rswd_pkg.
module rswd_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  rswd_pkg::rswd_rot_t rot_in,
	output logic               vld_out,
	output rswd_pkg::rswd_rot_t rot_out
);
	import rswd_pkg::*;

	localparam logic [PHASE_W-1:0] ATAN_K = PHASE_W'(ATAN_TURN[STEP]);

	logic signed [XY_W-1:0] x_c;
	logic signed [XY_W-1:0] y_c;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic                   y_pos;
	rswd_rot_t              rot_nxt;
	logic                   vld_q;
	rswd_rot_t              rot_q;

	always_comb begin
		x_c   = rot_in.x;
		y_c   = rot_in.y;
		dx    = y_c >>> STEP;
		dy    = x_c >>> STEP;
		y_pos = (y_c[XY_W-1] == 1'b0) && (y_c != '0);
		rot_nxt = rot_in;
		if (y_pos) begin
			rot_nxt.x   = x_c + dx;
			rot_nxt.y   = y_c - dy;
			rot_nxt.ang = rot_in.ang + ATAN_K;
		end else begin
			rot_nxt.x   = x_c - dx;
			rot_nxt.y   = y_c + dy;
			rot_nxt.ang = rot_in.ang - ATAN_K;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rot_q <= rot_nxt;
	end

	assign vld_out = vld_q;
	assign rot_out = rot_q;

endmodule

[hw/rtl/ring_sensor_window_direction.sv]
// Top level of the ring sensor window direction block.
// Depends on rswd_pkg, rswd_sensor_cell and rswd_cordic_cell.
//
// Usage:
//   A command transfer happens at each rising edge with start high and busy
//   low. busy is always low: the block takes a new sensor snapshot every
//   cycle, one item per clock sustained.
//   Each item yields exactly one result, shown on result for one cycle with
//   done high. The receiver cannot stall, so nothing is held back.
//   From the command transfer to done an item passes these registered stages:
//     window setup (start position modulo the ring, span = 2*half)
//     the scan chain, SENSOR_COUNT sensor cells, every cell
//       adding cos/sin of its own angle times how often the window covers it
//     vector setup (scale by 2^16, fold the left half-plane)
//     the vectoring chain, 30 cells, one CORDIC iteration per cell
//     rounding to ANGLE_BITS and the output register
//   The latency grows with the scan chain length; the rate is one item per cycle.
//   Reset clears every valid bit in the chains and done; payload registers
//   are not reset and no result is shown until a command has gone through.
module ring_sensor_window_direction #(
	parameter int SENSOR_COUNT = rswd_pkg::SENSOR_COUNT_DEF,
	parameter int ANGLE_BITS   = rswd_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rswd_pkg::rswd_in_t  item,
	output logic               done,
	output rswd_pkg::rswd_out_t result
);
	import rswd_pkg::*;

	// Enough compare-subtract steps to bring center + 4N - half below N.
	localparam int RED_STEPS = (4 * SENSOR_COUNT + 31) / SENSOR_COUNT;
	localparam int RED_W     = 10;

	// Window setup stage.
	logic [RED_W-1:0] red_v;
	rswd_scan_t       scan_d;
	logic             vld_s1;
	rswd_scan_t       scan_s1;

	// Chains between cells.
	logic       scan_vld [SENSOR_COUNT+1];
	rswd_scan_t scan_ch  [SENSOR_COUNT+1];
	logic       rot_vld  [CORDIC_STEPS+1];
	rswd_rot_t  rot_ch   [CORDIC_STEPS+1];

	// Vector setup stage.
	logic signed [SUM_W-1:0] sx_f;
	logic signed [SUM_W-1:0] sy_f;
	logic signed [XY_W-1:0]  x0;
	logic signed [XY_W-1:0]  y0;
	rswd_rot_t               rot_d;
	logic                    vld_v;
	rswd_rot_t               rot_v;

	// Output stage.
	rswd_rot_t         rot_last;
	logic [PHASE_W:0]  ang_rnd;
	logic [ANGLE_BITS-1:0] dir_ab;
	logic [31:0]       dir_w;
	rswd_out_t         result_d;
	logic              done_q;
	rswd_out_t         result_q;

	// Every cycle is open for a command.
	assign busy = 1'b0;

	// Window start = (center - half) mod N, reduced by repeated subtraction.
	always_comb begin
		red_v = RED_W'(item.window_center) + RED_W'(4 * SENSOR_COUNT)
			- RED_W'(item.window_half_width);
		for (int k = 0; k < RED_STEPS; k++) begin
			if (red_v >= RED_W'(SENSOR_COUNT))
				red_v = red_v - RED_W'(SENSOR_COUNT);
		end
		scan_d.sensor_bits = item.sensor_bits;
		scan_d.start_pos   = POS_W'(red_v);
		scan_d.span        = {item.window_half_width, 1'b0};
		scan_d.sum_x       = '0;
		scan_d.sum_y       = '0;
		scan_d.hits        = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		scan_s1 <= scan_d;
	end

	assign scan_vld[0] = vld_s1;
	assign scan_ch[0]  = scan_s1;

	// Scan chain: one cell per ring position, each cell registers the partial sums.
	generate
		for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_sensor
			rswd_sensor_cell #(
				.SENSOR_COUNT(SENSOR_COUNT),
				.INDEX       (i)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.vld_in  (scan_vld[i]),
				.scan_in (scan_ch[i]),
				.vld_out (scan_vld[i+1]),
				.scan_out(scan_ch[i+1])
			);
		end
	endgenerate

	// Scale the sums by 2^16 and turn a left half-plane vector by half a turn.
	always_comb begin
		sx_f = scan_ch[SENSOR_COUNT].sum_x;
		sy_f = scan_ch[SENSOR_COUNT].sum_y;
		x0   = XY_W'(sx_f) <<< 16;
		y0   = XY_W'(sy_f) <<< 16;
		rot_d.zero = (sx_f == '0) && (sy_f == '0);
		rot_d.hits = scan_ch[SENSOR_COUNT].hits;
		if (x0[XY_W-1]) begin
			rot_d.x   = -x0;
			rot_d.y   = -y0;
			rot_d.ang = 32'h8000_0000;
		end else begin
			rot_d.x   = x0;
			rot_d.y   = y0;
			rot_d.ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_v <= 1'b0;
		end else begin
			vld_v <= scan_vld[SENSOR_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		rot_v <= rot_d;
	end

	assign rot_vld[0] = vld_v;
	assign rot_ch[0]  = rot_v;

	// Vectoring chain: one CORDIC iteration per cell.
	generate
		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
			rswd_cordic_cell #(
				.STEP(k)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.vld_in (rot_vld[k]),
				.rot_in (rot_ch[k]),
				.vld_out(rot_vld[k+1]),
				.rot_out(rot_ch[k+1])
			);
		end
	endgenerate

	// Round the phase half up to ANGLE_BITS and wrap; drop the angle when the
	// sums cancel or nothing was seen.
	always_comb begin
		rot_last = rot_ch[CORDIC_STEPS];
		ang_rnd  = {1'b0, rot_last.ang} + ((PHASE_W + 1)'(1) << (31 - ANGLE_BITS));
		dir_ab   = ang_rnd[31 -: ANGLE_BITS];
		dir_w    = rot_last.zero ? 32'h0 : 32'(dir_ab);
		result_d.found     = (rot_last.hits != '0);
		result_d.direction = dir_w[DIR_W-1:0];
		result_d.hit_count = rot_last.hits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rot_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
